### hdl/sbtl_pkg.sv
// ----------------------------------------------------------------------------
// sbtl_pkg
// Shared types, constants and the sine/cosine table builder for the sweep
// baseline target locator.
// ----------------------------------------------------------------------------
package sbtl_pkg;

  // Geometry and field widths
  localparam int PositionsDef = 15;
  localparam int CmdW         = 2;
  localparam int PosW         = 4;
  localparam int DistW        = 10;
  localparam int TensW        = 8;
  localparam int InDataW      = 16;
  localparam int OutDataW     = 16;
  localparam int ApbAddrW     = 4;
  localparam int ApbDataW     = 32;
  localparam int SweepPairs   = 3;

  // Shared multiplier and fixed-point layout
  localparam int MagW    = 17;
  localparam int MulAW   = 17;
  localparam int MulBW   = 10;
  localparam int ProdW   = MulAW + MulBW;
  localparam int QShift  = 16;
  localparam int DivShift = 11;

  // Arithmetic constants
  localparam int Percent   = 100;
  localparam int Recip10   = 205;
  localparam int AngleBase = 5;
  localparam int AngleStep = 82;
  localparam longint unsigned QOne    = 64'd65536;
  localparam longint unsigned QHalfPi = 64'd102944;

  // Reset values
  localparam logic [7:0] MinRangeRst = 8'd30;
  localparam logic [6:0] RatioRst    = 7'd80;
  localparam logic [7:0] XOffsetRst  = 8'd2;
  localparam logic [7:0] YOffsetRst  = 8'd94;
  localparam logic [7:0] NoTarget    = 8'hFF;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdCal    = 2'd1,
    CmdDetect = 2'd2,
    CmdEnd    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegMinRange = 2'd0,
    RegRatio    = 2'd1,
    RegXOffset  = 2'd2,
    RegYOffset  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0] min_range;
    logic [6:0] ratio_percent;
    logic [7:0] x_offset;
    logic [7:0] y_offset;
  } cfg_t;

  typedef struct packed {
    logic            sin_neg;
    logic [MagW-1:0] sin_mag;
    logic            cos_neg;
    logic [MagW-1:0] cos_mag;
  } sc_t;

  // Sine and cosine in Q16 sign/magnitude for sweep position p, pair j
  // (angle minus one step, at, plus one step). Evaluated at elaboration.
  function automatic sc_t sc_entry(int unsigned p, int unsigned j);
    longint unsigned a;
    longint unsigned theta;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned c;
    longint unsigned cm;
    sc_t             e;
    a     = ((longint'(AngleBase) + longint'(p)) * 1800) / 22
            + longint'(j) * AngleStep - AngleStep;
    theta = (a * 3142 * 65536 + 900000) / 1800000;
    q     = (theta / QHalfPi) & 64'd3;
    r     = theta % QHalfPi;
    x2    = (r * r) >> 16;
    // Sine series, Horner form
    t = QOne - x2 / 72;
    t = QOne - ((x2 * t) >> 16) / 42;
    t = QOne - ((x2 * t) >> 16) / 20;
    t = QOne - ((x2 * t) >> 16) / 6;
    s = (r * t) >> 16;
    // Cosine series, Horner form, floored at zero
    t  = QOne - x2 / 90;
    t  = QOne - ((x2 * t) >> 16) / 56;
    t  = QOne - ((x2 * t) >> 16) / 30;
    t  = QOne - ((x2 * t) >> 16) / 12;
    cm = ((x2 * t) >> 16) / 2;
    c  = (cm > QOne) ? 64'd0 : QOne - cm;
    // Map quadrant signs
    unique case (q)
      64'd0: begin
        e = '{1'b0, MagW'(s), 1'b0, MagW'(c)};
      end
      64'd1: begin
        e = '{1'b0, MagW'(c), 1'b1, MagW'(s)};
      end
      64'd2: begin
        e = '{1'b1, MagW'(s), 1'b1, MagW'(c)};
      end
      default: begin
        e = '{1'b1, MagW'(c), 1'b0, MagW'(s)};
      end
    endcase
    return e;
  endfunction

endpackage

### hdl/sweep_baseline_target_locator_core.sv
// ----------------------------------------------------------------------------
// sweep_baseline_target_locator_core
// Baseline store, nearest-target tracking and x/y output for a range sweep.
// ----------------------------------------------------------------------------
// One input word is taken at a time; s_axis_tready is low while it is being
// worked on. A clear is applied as it is accepted; a calibration reading passes
// through StCal, and a detect reading through StDetMul1, StDetMul2 and StDetCmp.
// An end of sweep with a target builds three results, each through two products,
// two offset adds, two divides by ten and StEmit, all products going through one
// shared 17x10 multiplier under the sequencer; without a target it emits three
// results from StEmit alone. Each result waits in the output register until
// m_axis_tready, and StEmit holds the sequencer while that register is still
// full. The baseline store and the nearest target come out of reset ready.
module sweep_baseline_target_locator_core #(
  parameter int POSITIONS = sbtl_pkg::PositionsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbtl_pkg::InDataW-1:0]   s_axis_tdata,  // [3:0] position, [13:4] distance
  input  logic [sbtl_pkg::CmdW-1:0]      s_axis_tuser,  // [1:0] command
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sbtl_pkg::OutDataW-1:0]  m_axis_tdata,  // [7:0] x_tens, [15:8] y_tens
  output logic                           m_axis_tuser,  // [0] found
  output logic                           m_axis_tlast,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbtl_pkg::ApbAddrW-1:0]  paddr,
  input  logic [sbtl_pkg::ApbDataW-1:0]  pwdata,
  output logic [sbtl_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import sbtl_pkg::*;

  localparam int PosIdxW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int PairW   = 2;
  localparam logic [PairW-1:0] LastPair = PairW'(SweepPairs - 1);

  typedef enum logic [3:0] {
    StIdle,
    StCal,
    StDetMul1,
    StDetMul2,
    StDetCmp,
    StXMul,
    StXAdd,
    StXDiv,
    StYMul,
    StYAdd,
    StYDiv,
    StEmit
  } state_e;

  // Configuration
  cfg_t cfg;

  sbtl_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // Constant sine/cosine table, one row per position
  sc_t sc_tab [POSITIONS][SweepPairs];

  for (genvar gp = 0; gp < POSITIONS; gp++) begin : g_pos
    for (genvar gj = 0; gj < SweepPairs; gj++) begin : g_pair
      localparam sc_t Entry = sc_entry(gp, gj);
      assign sc_tab[gp][gj] = Entry;
    end
  end

  // State
  state_e            state_q;
  logic [7:0]        base_q [POSITIONS];
  logic [7:0]        near_dist_q;
  logic [PosW-1:0]   near_pos_q;
  logic [PosW-1:0]   pos_q;
  logic              pos_ok_q;
  logic [DistW-1:0]  dist_q;
  logic [7:0]        work_dist_q;
  logic [PosW-1:0]   work_pos_q;
  logic              found_q;
  logic [PairW-1:0]  pair_q;
  logic [MulAW-1:0]  keep_q;
  logic [DistW-1:0]  v_q;
  logic [TensW-1:0]  x_tens_q;
  logic [ProdW-1:0]  prod_q;
  logic              out_valid_q;
  logic [TensW-1:0]  out_x_q;
  logic [TensW-1:0]  out_y_q;
  logic              out_found_q;
  logic              out_last_q;

  logic              in_acc;
  logic [PosW-1:0]   in_pos;
  logic [DistW-1:0]  in_dist;
  cmd_e              in_cmd;
  logic [7:0]        base_rd;
  sc_t               sc_cur;
  logic              mul_en;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [8:0]        prod_hi;
  logic [7:0]        add_off;
  logic              add_sub;
  logic [DistW:0]    add_sum;
  logic [DistW-1:0]  v_d;
  logic              det_hit;
  logic              cal_hit;
  logic              out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_pos        = s_axis_tdata[PosW-1:0];
  assign in_dist       = s_axis_tdata[PosW+DistW-1:PosW];
  assign in_cmd        = cmd_e'(s_axis_tuser);

  // Single read port of the baseline store and the table
  assign base_rd = base_q[PosIdxW'(pos_q)];
  assign sc_cur  = sc_tab[PosIdxW'(work_pos_q)][pair_q];

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      StDetMul1: begin
        mul_a = MulAW'(Percent);
        mul_b = dist_q;
      end
      StDetMul2: begin
        mul_a = MulAW'(base_rd);
        mul_b = MulBW'(cfg.ratio_percent);
      end
      StXMul: begin
        mul_a = sc_cur.sin_mag;
        mul_b = MulBW'(work_dist_q);
      end
      StYMul: begin
        mul_a = sc_cur.cos_mag;
        mul_b = MulBW'(work_dist_q);
      end
      StXDiv, StYDiv: begin
        mul_a = MulAW'(Recip10);
        mul_b = v_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Offset add/subtract with clamp at zero
  assign prod_hi = prod_q[QShift+8:QShift];
  assign add_off = (state_q == StYAdd) ? cfg.y_offset : cfg.x_offset;
  assign add_sub = (state_q == StYAdd) ? ~sc_cur.cos_neg : sc_cur.sin_neg;
  assign add_sum = add_sub ? ((DistW+1)'(add_off) - (DistW+1)'(prod_hi))
                           : ((DistW+1)'(add_off) + (DistW+1)'(prod_hi));
  assign v_d     = add_sum[DistW] ? '0 : add_sum[DistW-1:0];

  // Reading qualifiers
  assign cal_hit = pos_ok_q && (dist_q < DistW'(base_rd))
                   && (dist_q > DistW'(cfg.min_range));
  assign det_hit = pos_ok_q && (base_rd != '0) && (ProdW'(keep_q) < prod_q)
                   && (dist_q > DistW'(cfg.min_range))
                   && (dist_q < DistW'(near_dist_q));

  assign out_free = ~out_valid_q | m_axis_tready;

  // Hold the product of the shared unit
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
  end

  // Sequencer, store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      for (int i = 0; i < POSITIONS; i++) begin
        base_q[i] <= NoTarget;
      end
      near_dist_q <= NoTarget;
      near_pos_q  <= '0;
      pos_q       <= '0;
      pos_ok_q    <= 1'b0;
      dist_q      <= '0;
      work_dist_q <= '0;
      work_pos_q  <= '0;
      found_q     <= 1'b0;
      pair_q      <= '0;
      keep_q      <= '0;
      v_q         <= '0;
      x_tens_q    <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_found_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // Drop the result once taken; the emit state reloads the register itself
      if (m_axis_tready && (state_q != StEmit)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            pos_q    <= in_pos;
            dist_q   <= in_dist;
            pos_ok_q <= (32'(in_pos) < POSITIONS);
            unique case (in_cmd)
              CmdClear: begin
                for (int i = 0; i < POSITIONS; i++) begin
                  base_q[i] <= NoTarget;
                end
                near_dist_q <= NoTarget;
                near_pos_q  <= '0;
              end
              CmdCal: begin
                state_q <= StCal;
              end
              CmdDetect: begin
                state_q <= StDetMul1;
              end
              CmdEnd: begin
                work_dist_q <= near_dist_q;
                work_pos_q  <= near_pos_q;
                found_q     <= (near_dist_q != NoTarget);
                pair_q      <= '0;
                near_dist_q <= NoTarget;
                near_pos_q  <= '0;
                state_q     <= (near_dist_q != NoTarget) ? StXMul : StEmit;
              end
              default: begin
                state_q <= StIdle;
              end
            endcase
          end
        end
        StCal: begin
          if (cal_hit) begin
            base_q[PosIdxW'(pos_q)] <= dist_q[7:0];
          end
          state_q <= StIdle;
        end
        StDetMul1: begin
          state_q <= StDetMul2;
        end
        StDetMul2: begin
          keep_q  <= prod_q[MulAW-1:0];
          state_q <= StDetCmp;
        end
        StDetCmp: begin
          if (det_hit) begin
            near_dist_q <= dist_q[7:0];
            near_pos_q  <= pos_q;
          end
          state_q <= StIdle;
        end
        StXMul: begin
          state_q <= StXAdd;
        end
        StXAdd: begin
          v_q     <= v_d;
          state_q <= StXDiv;
        end
        StXDiv: begin
          state_q <= StYMul;
        end
        StYMul: begin
          x_tens_q <= prod_q[DivShift+TensW-1:DivShift];
          state_q  <= StYAdd;
        end
        StYAdd: begin
          v_q     <= v_d;
          state_q <= StYDiv;
        end
        StYDiv: begin
          state_q <= StEmit;
        end
        StEmit: begin
          // Load the result once the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= found_q ? x_tens_q : '0;
            out_y_q     <= found_q ? prod_q[DivShift+TensW-1:DivShift] : '0;
            out_found_q <= found_q;
            out_last_q  <= (pair_q == LastPair);
            pair_q      <= pair_q + 1'b1;
            if (pair_q == LastPair) begin
              state_q <= StIdle;
            end else if (found_q) begin
              state_q <= StXMul;
            end else begin
              state_q <= StEmit;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/sbtl_regs.sv
// ----------------------------------------------------------------------------
// sbtl_regs
// APB configuration registers: minimum range, ratio threshold, sensor
// x and y offsets.
// ----------------------------------------------------------------------------
module sbtl_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [sbtl_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [sbtl_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [sbtl_pkg::ApbDataW-1:0]  prdata_o,
  output sbtl_pkg::cfg_t                 cfg_o
);
  import sbtl_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e wr_sel;
  reg_e rd_sel;

  assign wr_en  = psel_i & penable_i & pwrite_i;
  assign wr_sel = reg_e'(paddr_i[3:2]);
  assign rd_sel = reg_e'(paddr_i[3:2]);

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range     <= MinRangeRst;
      cfg_q.ratio_percent <= RatioRst;
      cfg_q.x_offset      <= XOffsetRst;
      cfg_q.y_offset      <= YOffsetRst;
    end else if (wr_en) begin
      unique case (wr_sel)
        RegMinRange: cfg_q.min_range     <= pwdata_i[7:0];
        RegRatio:    cfg_q.ratio_percent <= pwdata_i[6:0];
        RegXOffset:  cfg_q.x_offset      <= pwdata_i[7:0];
        RegYOffset:  cfg_q.y_offset      <= pwdata_i[7:0];
        default:     cfg_q.min_range     <= cfg_q.min_range;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (rd_sel)
      RegMinRange: prdata_o = ApbDataW'(cfg_q.min_range);
      RegRatio:    prdata_o = ApbDataW'(cfg_q.ratio_percent);
      RegXOffset:  prdata_o = ApbDataW'(cfg_q.x_offset);
      RegYOffset:  prdata_o = ApbDataW'(cfg_q.y_offset);
      default:     prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/sbtl_checker.sv
// ----------------------------------------------------------------------------
// sbtl_checker
// Port-level checks for the sweep baseline target locator, bound to the
// top level.
// ----------------------------------------------------------------------------
module sbtl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [sbtl_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [sbtl_pkg::CmdW-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sbtl_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import sbtl_pkg::*;

  localparam logic [TensW-1:0] MaxTens = 8'd51;

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("sbtl: stalled result word changed");

  // No-target results carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("sbtl: no-target result with nonzero coordinates");

  // Coordinates in tens never exceed the largest offset plus range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TensW-1:0] <= MaxTens)
      && (m_axis_tdata[2*TensW-1:TensW] <= MaxTens))
    else $error("sbtl: coordinate out of range");

  // End of sweep blocks further input while results are built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdEnd) |=> !s_axis_tready)
    else $error("sbtl: input taken during end of sweep");

endmodule

bind sweep_baseline_target_locator_core sbtl_checker u_sbtl_checker (.*);

### test/tb_sweep_baseline_target_locator_core.sv
// ----------------------------------------------------------------------------
// tb_sweep_baseline_target_locator_core
// Self-checking bench for the sweep baseline target locator: a queue-fed
// stream driver, a random-stall result sink, an APB register writer and a
// bit-exact fixed-point predictor that checks every fix word in order.
// ----------------------------------------------------------------------------
module tb_sweep_baseline_target_locator_core;
  import sbtl_pkg::*;

  localparam int Positions  = PositionsDef;
  localparam int SettleCyc  = 30;
  localparam int HoldCyc    = 300;
  localparam int StallLimit = 3000;
  localparam int MaxReports = 10;
  localparam longint unsigned Q16One    = 64'd65536;
  localparam longint unsigned Q16HalfPi = 64'd102944;

  typedef struct {
    cmd_e       cmd;
    logic [3:0] pos;
    logic [9:0] range_cm;
  } reading_t;

  typedef struct packed {
    logic [7:0] x_tens;
    logic [7:0] y_tens;
    logic       found;
    logic       last;
  } fix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [3:0] position, [13:4] distance
  logic [1:0]  s_axis_tuser = '0;  // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // [7:0] x_tens, [15:8] y_tens
  logic        m_axis_tuser;       // [0] found
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and expectation stores
  reading_t reading_q[$];
  fix_t     fix_q[$];

  // Predictor state and register shadows
  logic [7:0] baseline [Positions];
  logic [7:0] near_dist;
  logic [3:0] near_pos;
  logic [7:0] lim_min;
  logic [6:0] lim_ratio;
  logic [7:0] off_x;
  logic [7:0] off_y;

  bit in_fire;
  bit idle_en;
  bit hold_req;
  int hold_left;
  int stall_cycles;
  int readings_taken;
  int fixes_checked;
  int sweeps_ended;
  int settings_applied;
  int mism_cnt;

  sweep_baseline_target_locator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Range times a signed Q16 factor, truncated toward zero
  function automatic longint scale_trunc(logic [7:0] d, longint f);
    longint unsigned mag;
    longint          prod;
    mag  = (f < 0) ? -f : f;
    prod = longint'((longint'(d) * mag) >> 16);
    return (f < 0) ? -prod : prod;
  endfunction

  // Advance the predictor by one accepted reading, queue any fixes it causes
  function automatic void locate_step(cmd_e c, logic [3:0] p, logic [9:0] d);
    int unsigned     pct;
    longint unsigned ang, theta, quad, rem, sq, h, smag;
    longint          cmag, sn, cs, xv, yv;
    fix_t            fix;
    case (c)
      CmdClear: begin
        foreach (baseline[i]) baseline[i] = NoTarget;
        near_dist = NoTarget;
        near_pos  = '0;
      end
      CmdCal: begin
        if (p < Positions && d < baseline[p] && d > lim_min) baseline[p] = d[7:0];
      end
      CmdDetect: begin
        if (p < Positions && baseline[p] != 0) begin
          pct = (d * 100) / baseline[p];
          if (pct < lim_ratio && d > lim_min && d < near_dist) begin
            near_dist = d[7:0];
            near_pos  = p;
          end
        end
      end
      default: begin
        sweeps_ended++;
        for (int j = 0; j < SweepPairs; j++) begin
          fix = '0;
          if (near_dist != NoTarget) begin
            ang   = ((AngleBase + near_pos) * 1800) / 22 + j * AngleStep - AngleStep;
            theta = (ang * 3142 * 65536 + 900000) / 1800000;
            quad  = (theta / Q16HalfPi) & 64'd3;
            rem   = theta % Q16HalfPi;
            sq    = (rem * rem) >> 16;
            // sine series to the ninth power
            h    = Q16One - sq / 72;
            h    = Q16One - ((sq * h) >> 16) / 42;
            h    = Q16One - ((sq * h) >> 16) / 20;
            h    = Q16One - ((sq * h) >> 16) / 6;
            smag = (rem * h) >> 16;
            // cosine series to the tenth power, floored at zero
            h    = Q16One - sq / 90;
            h    = Q16One - ((sq * h) >> 16) / 56;
            h    = Q16One - ((sq * h) >> 16) / 30;
            h    = Q16One - ((sq * h) >> 16) / 12;
            cmag = longint'(Q16One) - longint'(((sq * h) >> 16) / 2);
            if (cmag < 0) cmag = 0;
            case (quad)
              64'd0: begin sn = smag;  cs = cmag;  end
              64'd1: begin sn = cmag;  cs = -smag; end
              64'd2: begin sn = -smag; cs = -cmag; end
              default: begin sn = -cmag; cs = smag; end
            endcase
            xv = longint'(off_x) + scale_trunc(near_dist, sn);
            yv = longint'(off_y) - scale_trunc(near_dist, cs);
            if (xv < 0) xv = 0;
            if (yv < 0) yv = 0;
            fix.x_tens = 8'(xv / 10);
            fix.y_tens = 8'(yv / 10);
            fix.found  = 1'b1;
          end
          fix.last = (j == SweepPairs - 1);
          fix_q.push_back(fix);
        end
        near_dist = NoTarget;
        near_pos  = '0;
      end
    endcase
  endfunction

  function automatic void add_reading(cmd_e c, int unsigned p, int unsigned d);
    reading_t r;
    r.cmd      = c;
    r.pos      = p[3:0];
    r.range_cm = d[9:0];
    reading_q.push_back(r);
  endfunction

  // Queue one sweep: optional clear and calibration, detects, an occasional stray word, end of sweep
  task automatic queue_sweep();
    int unsigned n;
    if ($urandom_range(0, 99) < 15) begin
      add_reading(CmdClear, $urandom_range(0, 15), $urandom_range(0, 1023));
      n = $urandom_range(2, 8);
      repeat (n) add_reading(CmdCal, $urandom_range(0, 14), $urandom_range(40, 254));
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 99) < 80)
        add_reading(CmdDetect, $urandom_range(0, 14), $urandom_range(0, 255));
      else
        add_reading(CmdDetect, $urandom_range(0, 15), $urandom_range(0, 1023));
    end
    // occasional stray word of any kind
    if ($urandom_range(0, 99) < 10)
      add_reading(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 15),
                  $urandom_range(0, 1023));
    add_reading(CmdEnd, $urandom_range(0, 15), $urandom_range(0, 1023));
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned target;
    target = reading_q.size() + count;
    while (reading_q.size() < target) queue_sweep();
  endtask

  // Wait until every reading is taken and every fix has come back
  task automatic drain();
    while (reading_q.size() != 0 || s_axis_tvalid || fix_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_setting(reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegMinRange: lim_min   = val[7:0];
      RegRatio:    lim_ratio = val[6:0];
      RegXOffset:  off_x     = val[7:0];
      default:     off_y     = val[7:0];
    endcase
    settings_applied++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned mr, int unsigned rp, int unsigned xo,
                                int unsigned yo);
    write_setting(RegMinRange, mr);
    write_setting(RegRatio, rp);
    write_setting(RegXOffset, xo);
    write_setting(RegYOffset, yo);
  endtask

  // Take a reading word and predict its fixes
  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      locate_step(cmd_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[13:4]);
      readings_taken++;
    end
  end

  // Offer the next reading; hold the word until it is taken
  always @(negedge clk_i) begin : feed
    reading_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (reading_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < 9)) begin
        r = reading_q.pop_front();
        s_axis_tdata  <= {2'b00, r.range_cm, r.pos};
        s_axis_tuser  <= r.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCyc;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 9);
    end
  end

  // Check each fix word against the oldest expectation
  always @(posedge clk_i) begin : fix_check
    fix_t got;
    fix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser, m_axis_tlast};
      if (fix_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MaxReports)
          $display("[%0t] unexpected fix word x=%0d y=%0d found=%0b last=%0b",
                   $realtime, got.x_tens, got.y_tens, got.found, got.last);
      end else begin
        want = fix_q.pop_front();
        fixes_checked++;
        if (got != want) begin
          mism_cnt++;
          if (mism_cnt <= MaxReports)
            $display({"[%0t] fix mismatch: expected x=%0d y=%0d found=%0b last=%0b,",
                      " got x=%0d y=%0d found=%0b last=%0b"}, $realtime,
                     want.x_tens, want.y_tens, want.found, want.last,
                     got.x_tens, got.y_tens, got.found, got.last);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("Watchdog: no word moved for %0d cycles", StallLimit);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (baseline[i]) baseline[i] = NoTarget;
    near_dist = NoTarget;
    near_pos  = '0;
    lim_min   = MinRangeRst;
    lim_ratio = RatioRst;
    off_x     = XOffsetRst;
    off_y     = YOffsetRst;
    idle_en   = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty sweep, ignored readings, ties, clamp, clear
    add_reading(CmdEnd, 0, 0);
    add_reading(CmdCal, 14, 200);
    add_reading(CmdCal, 14, 30);
    add_reading(CmdCal, 15, 50);
    add_reading(CmdDetect, 15, 40);
    add_reading(CmdDetect, 14, 150);
    add_reading(CmdDetect, 13, 150);
    add_reading(CmdDetect, 14, 31);
    add_reading(CmdDetect, 0, 1023);
    add_reading(CmdDetect, 0, 0);
    add_reading(CmdEnd, 15, 1023);
    add_reading(CmdEnd, 0, 0);
    add_reading(CmdDetect, 0, 180);
    add_reading(CmdEnd, 0, 0);
    add_reading(CmdDetect, 7, 100);
    add_reading(CmdClear, 15, 1023);
    add_reading(CmdEnd, 0, 0);
    add_reading(CmdCal, 5, 1023);
    add_reading(CmdCal, 5, 254);
    add_reading(CmdDetect, 5, 200);
    add_reading(CmdDetect, 10, 203);
    add_reading(CmdEnd, 0, 0);
    add_reading(CmdDetect, 9, 10);
    add_reading(CmdEnd, 0, 0);
    drain();

    // Random sweeps at reset settings
    queue_random(40);
    drain();

    // Widest settings, no idling on either side
    apply_settings(0, 100, 255, 255);
    idle_en = 1'b0;
    queue_random(30);
    drain();
    idle_en = 1'b1;

    // Nothing can qualify
    apply_settings(255, 0, 0, 0);
    queue_random(15);
    drain();

    // Mid settings with a long result hold-off while readings keep coming
    apply_settings($urandom_range(5, 60), $urandom_range(50, 100), $urandom_range(0, 255),
                   $urandom_range(0, 255));
    hold_req = 1'b1;
    queue_random(30);
    drain();

    apply_settings($urandom_range(0, 255), $urandom_range(0, 100), $urandom_range(0, 255),
                   $urandom_range(0, 255));
    queue_random(15);
    drain();

    if (fix_q.size() != 0) begin
      mism_cnt += fix_q.size();
      $display("%0d expected fix words never arrived", fix_q.size());
    end
    $display("Run: %0d readings taken, %0d fix words checked over %0d sweep ends,",
             readings_taken, fixes_checked, sweeps_ended);
    $display("     %0d register writes incl. extreme settings and a long output stall",
             settings_applied);
    if (mism_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/sbtl_pkg.sv
hdl/sbtl_regs.sv
hdl/sweep_baseline_target_locator_core.sv
hdl/sbtl_checker.sv
test/tb_sweep_baseline_target_locator_core.sv
